>>> hw/rtl/uvs_pkg.sv
// Shared constants, types and helper functions of the UV sphere vertex generator.
package uvs_pkg;

    // Width of counts and grid indices.
    localparam int COUNT_BITS = 8;
    // Fraction bits of the position outputs.
    localparam int COORD_FRAC_BITS = 14;

    // Divider chain: one integer quotient bit and 33 fraction bits.
    localparam int DIV_CELLS = 34;
    // Latency of the sine/cosine pipeline.
    localparam int SC_LAT = 16;
    // Sideband delay from input to the product stage.
    localparam int SB_LEN = DIV_CELLS + 1 + SC_LAT + 1;
    // Texture delay from the angle stage to the product stage.
    localparam int TX_LEN = SC_LAT + 1;
    localparam int HORNER_STEPS = 5;

    // Configuration register indexes.
    localparam logic REG_SECTOR_COUNT = 1'b0;
    localparam logic REG_STACK_COUNT  = 1'b1;

    localparam logic [COUNT_BITS-1:0] SECTOR_RESET = COUNT_BITS'(24);
    localparam logic [COUNT_BITS-1:0] STACK_RESET  = COUNT_BITS'(16);

    // Q30 one and pi in Q30.
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [29:0] EIGHTH_Q30 = 30'h2000_0000;

    // Rounding shifts of the outputs.
    localparam logic [5:0] SH_PROD = 6'(60 - COORD_FRAC_BITS);
    localparam logic [5:0] SH_COS  = 6'(30 - COORD_FRAC_BITS);

    // Reciprocals for exact division of values below 2^30 by the series constants:
    // recip = ceil(2^(30+L)/d), quotient = (n * recip) >> (30+L), L = ceil(log2 d).
    localparam logic [31:0] SIN_RECIP [HORNER_STEPS] = '{
        32'(((64'd1 << 37) + 64'd109) / 64'd110),
        32'(((64'd1 << 37) + 64'd71)  / 64'd72),
        32'(((64'd1 << 36) + 64'd41)  / 64'd42),
        32'(((64'd1 << 35) + 64'd19)  / 64'd20),
        32'(((64'd1 << 33) + 64'd5)   / 64'd6)
    };
    localparam logic [5:0] SIN_SHIFT [HORNER_STEPS] = '{6'd37, 6'd37, 6'd36, 6'd35, 6'd33};

    localparam logic [31:0] COS_RECIP [HORNER_STEPS] = '{
        32'(((64'd1 << 38) + 64'd131) / 64'd132),
        32'(((64'd1 << 37) + 64'd89)  / 64'd90),
        32'(((64'd1 << 36) + 64'd55)  / 64'd56),
        32'(((64'd1 << 35) + 64'd29)  / 64'd30),
        32'(((64'd1 << 34) + 64'd11)  / 64'd12)
    };
    localparam logic [5:0] COS_SHIFT [HORNER_STEPS] = '{6'd38, 6'd37, 6'd36, 6'd35, 6'd34};

    // Per-item data that rides beside the arithmetic.
    typedef struct packed {
        logic        pv;
        logic        qv;
        logic [15:0] cur;
        logic [15:0] nxt;
    } t_side;

    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
    } t_tex;

    // Round half away from zero by sh bits and clamp to signed 16 bits.
    function automatic logic [15:0] to_coord(input logic signed [63:0] v, input logic [5:0] sh);
        logic        neg;
        logic [63:0] m;
        logic [63:0] half;
        logic [15:0] res;
        neg  = v[63];
        m    = neg ? 64'(-v) : 64'(v);
        half = (64'd1 << sh) >> 1;
        m    = (m + half) >> sh;
        if (neg) begin
            res = (m > 64'd32768) ? 16'h8000 : 16'(-m);
        end else begin
            res = (m > 64'd32767) ? 16'h7FFF : m[15:0];
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/uvs_div_cell.sv
// One restoring division step: compares, subtracts and shifts in one quotient bit.
module uvs_div_cell (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [uvs_pkg::COUNT_BITS:0]        i_rem,
    input  logic [uvs_pkg::COUNT_BITS-1:0]      i_div,
    input  logic [uvs_pkg::DIV_CELLS-1:0]       i_quo,
    output logic [uvs_pkg::COUNT_BITS-1:0]      o_rem,
    output logic [uvs_pkg::DIV_CELLS-1:0]       o_quo
);

    logic                              w_ge;
    logic [uvs_pkg::COUNT_BITS:0]      w_diff;
    logic [uvs_pkg::COUNT_BITS-1:0]    r_rem;
    logic [uvs_pkg::DIV_CELLS-1:0]     r_quo;

    // Trial subtraction of the divisor.
    assign w_ge   = i_rem >= {1'b0, i_div};
    assign w_diff = i_rem - {1'b0, i_div};

    // Keep the partial remainder and append the new quotient bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[uvs_pkg::COUNT_BITS-1:0]
                          : i_rem[uvs_pkg::COUNT_BITS-1:0];
            r_quo <= {i_quo[uvs_pkg::DIV_CELLS-2:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

>>> hw/rtl/uvs_horner_step.sv
// One Horner step of a series: t' = 1 - ((x2 * t) >> 30) / d over two stages.
module uvs_horner_step (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [29:0] i_x2,
    input  logic [30:0] i_t,
    input  logic [31:0] i_recip,
    input  logic [5:0]  i_shift,
    output logic [29:0] o_x2,
    output logic [30:0] o_t
);

    logic [61:0] w_prod;
    logic [61:0] w_quo;
    logic [29:0] r_p;
    logic [29:0] r_x2a;
    logic [30:0] r_t;
    logic [29:0] r_x2b;

    // First stage: the Q30 product of x squared and the running term.
    assign w_prod = 62'(i_x2) * 62'(i_t);

    // Second stage: divide by the series constant through its reciprocal.
    assign w_quo = (62'(r_p) * 62'(i_recip)) >> i_shift;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= w_prod[59:30];
            r_x2a <= i_x2;
            r_t   <= uvs_pkg::ONE_Q30 - w_quo[30:0];
            r_x2b <= r_x2a;
        end
    end

    assign o_x2 = r_x2b;
    assign o_t  = r_t;

endmodule

>>> hw/rtl/uvs_sincos.sv
// Pipelined sine and cosine of an angle in turns, Q30 results.
module uvs_sincos (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_angle,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int XD_LEN = 2 * uvs_pkg::HORNER_STEPS;
    localparam int QD_LEN = XD_LEN + 2;

    logic        w_fold;
    logic [29:0] w_rf;
    logic [61:0] w_xp;
    logic [59:0] w_x2p;
    logic [1:0]  r1_quad;
    logic        r1_fold;
    logic [29:0] r1_rf;
    logic [1:0]  r2_quad;
    logic        r2_fold;
    logic [29:0] r2_x;
    logic [1:0]  r3_quad;
    logic        r3_fold;
    logic [29:0] r3_x;
    logic [29:0] r3_x2;
    logic [29:0] r_xd [XD_LEN];
    logic [1:0]  r_qd [QD_LEN];
    logic        r_fd [QD_LEN];

    logic [29:0] w_sx2 [uvs_pkg::HORNER_STEPS+1];
    logic [30:0] w_st  [uvs_pkg::HORNER_STEPS+1];
    logic [29:0] w_cx2 [uvs_pkg::HORNER_STEPS+1];
    logic [30:0] w_ct  [uvs_pkg::HORNER_STEPS+1];

    logic [60:0] w_s0p;
    logic [60:0] w_cpp;
    logic [29:0] r_s0;
    logic [29:0] r_s0b;
    logic [29:0] r_cp;
    logic [30:0] r_c0;
    logic signed [31:0] w_s;
    logic signed [31:0] w_c;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;

    // Fold the angle into the first half of a quadrant.
    assign w_fold = i_angle[29:0] > uvs_pkg::EIGHTH_Q30;
    assign w_rf   = w_fold ? 30'(uvs_pkg::ONE_Q30 - {1'b0, i_angle[29:0]}) : i_angle[29:0];

    // Turn fraction to radians, then the square.
    assign w_xp  = (62'(r1_rf) * 62'(uvs_pkg::PI_Q30)) + 62'(uvs_pkg::ONE_Q30);
    assign w_x2p = 60'(r2_x) * 60'(r2_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_quad <= i_angle[31:30];
            r1_fold <= w_fold;
            r1_rf   <= w_rf;
            r2_quad <= r1_quad;
            r2_fold <= r1_fold;
            r2_x    <= w_xp[60:31];
            r3_quad <= r2_quad;
            r3_fold <= r2_fold;
            r3_x    <= r2_x;
            r3_x2   <= w_x2p[59:30];
        end
    end

    // Delay lines that keep x, quadrant and fold aligned with the series.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xd[0] <= r3_x;
            for (int k = 1; k < XD_LEN; k++) begin
                r_xd[k] <= r_xd[k-1];
            end
            r_qd[0] <= r3_quad;
            r_fd[0] <= r3_fold;
            for (int k = 1; k < QD_LEN; k++) begin
                r_qd[k] <= r_qd[k-1];
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // Two chains of Horner steps: sine terms and cosine terms.
    assign w_sx2[0] = r3_x2;
    assign w_st[0]  = uvs_pkg::ONE_Q30;
    assign w_cx2[0] = r3_x2;
    assign w_ct[0]  = uvs_pkg::ONE_Q30;

    for (genvar g = 0; g < uvs_pkg::HORNER_STEPS; g++) begin : g_step
        uvs_horner_step u_sin_step (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_x2    (w_sx2[g]),
            .i_t     (w_st[g]),
            .i_recip (uvs_pkg::SIN_RECIP[g]),
            .i_shift (uvs_pkg::SIN_SHIFT[g]),
            .o_x2    (w_sx2[g+1]),
            .o_t     (w_st[g+1])
        );
        uvs_horner_step u_cos_step (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_x2    (w_cx2[g]),
            .i_t     (w_ct[g]),
            .i_recip (uvs_pkg::COS_RECIP[g]),
            .i_shift (uvs_pkg::COS_SHIFT[g]),
            .o_x2    (w_cx2[g+1]),
            .o_t     (w_ct[g+1])
        );
    end

    // Last terms: sine times x, cosine one more half step.
    assign w_s0p = 61'(r_xd[XD_LEN-1]) * 61'(w_st[uvs_pkg::HORNER_STEPS]);
    assign w_cpp = 61'(w_cx2[uvs_pkg::HORNER_STEPS]) * 61'(w_ct[uvs_pkg::HORNER_STEPS]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0  <= w_s0p[59:30];
            r_cp  <= w_cpp[59:30];
            r_s0b <= r_s0;
            r_c0  <= uvs_pkg::ONE_Q30 - {2'b00, r_cp[29:1]};
        end
    end

    // Undo the fold, then place the pair in its quadrant.
    assign w_s = r_fd[QD_LEN-1] ? $signed({1'b0, r_c0}) : $signed({2'b00, r_s0b});
    assign w_c = r_fd[QD_LEN-1] ? $signed({2'b00, r_s0b}) : $signed({1'b0, r_c0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_qd[QD_LEN-1])
                2'd0: begin
                    r_sin <= w_s;
                    r_cos <= w_c;
                end
                2'd1: begin
                    r_sin <= w_c;
                    r_cos <= -w_s;
                end
                2'd2: begin
                    r_sin <= -w_s;
                    r_cos <= -w_c;
                end
                default: begin
                    r_sin <= -w_c;
                    r_cos <= w_s;
                end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

>>> hw/rtl/uv_sphere_vertex_generator.sv
// Top level: unit UV sphere vertex, texture and corner index generator.
//
//  Channel   Direction  Transfer on                     Payload
//  s_axis    in         s_axis_tvalid & s_axis_tready   tdata: stack_idx, sector_idx
//  m_axis    out        m_axis_tvalid & m_axis_tready   tdata: positions, tex, corners;
//                                                       tuser: point_valid, quad_valid
//  cfg       in         i_cfg_we                        i_cfg_idx, i_cfg_data
//
// One grid point is accepted per cycle while the output is not stalled.
// Each result passes through the 34-cell divider chain and the 16-stage sine/cosine pipeline.
// Synchronous reset clears the stage valid bits and loads the default counts.
// When a result waits at the output, the whole pipeline holds and s_axis_tready drops.
module uv_sphere_vertex_generator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // [7:0] stack_idx, [15:8] sector_idx
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v,
                                          // corner_cur, corner_next (16 bits each)
    output logic [1:0]    m_axis_tuser,   // [0] point_valid, [1] quad_valid
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);

    localparam int CB = uvs_pkg::COUNT_BITS;
    localparam int DC = uvs_pkg::DIV_CELLS;

    logic [CB-1:0] r_sectors;
    logic [CB-1:0] r_stacks;
    logic          w_en;
    logic          w_acc;
    logic [CB-1:0] w_i;
    logic [CB-1:0] w_j;
    logic          w_pv;
    logic          w_qv;
    logic [31:0]   w_cur;
    uvs_pkg::t_side w_side;

    logic [CB-1:0] w_rem_i [DC];
    logic [DC-1:0] w_quo_i [DC];
    logic [CB-1:0] w_rem_j [DC];
    logic [DC-1:0] w_quo_j [DC];

    logic [34:0]   w_phi_sum;
    logic [34:0]   w_theta_sum;
    logic [17:0]   w_u_sum;
    logic [17:0]   w_v_sum;
    logic [31:0]   r_phi;
    logic [31:0]   r_theta;
    uvs_pkg::t_tex r_tex;

    logic                  r_vld [uvs_pkg::SB_LEN];
    uvs_pkg::t_side        r_sb  [uvs_pkg::SB_LEN];
    uvs_pkg::t_tex         r_tx  [uvs_pkg::TX_LEN];

    logic signed [31:0] w_sp;
    logic signed [31:0] w_cp;
    logic signed [31:0] w_st;
    logic signed [31:0] w_ct;
    logic signed [63:0] r_px;
    logic signed [63:0] r_pz;
    logic signed [31:0] r_py;

    logic          r_out_vld;
    logic [111:0]  r_out_data;
    logic [1:0]    r_out_user;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sectors <= uvs_pkg::SECTOR_RESET;
            r_stacks  <= uvs_pkg::STACK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                uvs_pkg::REG_SECTOR_COUNT: r_sectors <= CB'(i_cfg_data);
                uvs_pkg::REG_STACK_COUNT:  r_stacks  <= CB'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register can take a result.
    assign w_en          = m_axis_tready || !r_out_vld;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;

    // Input decode: validity and flat corner indices.
    assign w_i   = CB'(s_axis_tdata[7:0]);
    assign w_j   = CB'(s_axis_tdata[15:8]);
    assign w_pv  = (r_sectors != '0) && (r_stacks != '0) && (w_i <= r_stacks)
                   && (w_j <= r_sectors);
    assign w_qv  = w_pv && (w_i < r_stacks) && (w_j < r_sectors);
    assign w_cur = 32'(w_i) * (32'(r_sectors) + 32'd1) + 32'(w_j);

    always_comb begin
        w_side.pv  = w_pv;
        w_side.qv  = w_qv;
        w_side.cur = w_pv ? w_cur[15:0] : 16'd0;
        w_side.nxt = w_qv ? 16'(w_cur + 32'(r_sectors) + 32'd1) : 16'd0;
    end

    // Divider chains: i over stacks and j over sectors, one quotient bit per cell.
    for (genvar k = 0; k < DC; k++) begin : g_div
        logic [CB:0]   w_ri;
        logic [CB:0]   w_rj;
        logic [DC-1:0] w_qi;
        logic [DC-1:0] w_qj;
        if (k == 0) begin : g_first
            assign w_ri = {1'b0, w_i};
            assign w_rj = {1'b0, w_j};
            assign w_qi = '0;
            assign w_qj = '0;
        end else begin : g_next
            assign w_ri = {w_rem_i[k-1], 1'b0};
            assign w_rj = {w_rem_j[k-1], 1'b0};
            assign w_qi = w_quo_i[k-1];
            assign w_qj = w_quo_j[k-1];
        end
        uvs_div_cell u_cell_i (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_ri),
            .i_div (r_stacks),
            .i_quo (w_qi),
            .o_rem (w_rem_i[k]),
            .o_quo (w_quo_i[k])
        );
        uvs_div_cell u_cell_j (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_rj),
            .i_div (r_sectors),
            .i_quo (w_qj),
            .o_rem (w_rem_j[k]),
            .o_quo (w_quo_j[k])
        );
    end

    // Round the quotients into angles in turns and texture coordinates.
    assign w_phi_sum   = 35'(w_quo_i[DC-1][DC-1:1]) + 35'd1;
    assign w_theta_sum = 35'(w_quo_j[DC-1]) + 35'd1;
    assign w_u_sum     = 18'(w_quo_j[DC-1][DC-1:17]) + 18'd1;
    assign w_v_sum     = 18'(w_quo_i[DC-1][DC-1:17]) + 18'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phi   <= w_phi_sum[32:1];
            r_theta <= w_theta_sum[32:1];
            r_tex.u <= w_u_sum[16:1];
            r_tex.v <= w_v_sum[16:1];
        end
    end

    // Sine and cosine of both angles.
    uvs_sincos u_sc_phi (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_phi),
        .o_sin   (w_sp),
        .o_cos   (w_cp)
    );

    uvs_sincos u_sc_theta (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_theta),
        .o_sin   (w_st),
        .o_cos   (w_ct)
    );

    // Valid bits travel with the item and are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < uvs_pkg::SB_LEN; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_acc;
            for (int k = 1; k < uvs_pkg::SB_LEN; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Sideband and texture delay lines.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= w_side;
            for (int k = 1; k < uvs_pkg::SB_LEN; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_tx[0] <= r_tex;
            for (int k = 1; k < uvs_pkg::TX_LEN; k++) begin
                r_tx[k] <= r_tx[k-1];
            end
        end
    end

    // Products of the sines and cosines.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= 64'(w_sp) * 64'(w_ct);
            r_pz <= 64'(w_sp) * 64'(w_st);
            r_py <= w_cp;
        end
    end

    // Output register: round, clamp and zero points outside the mesh.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[uvs_pkg::SB_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_sb[uvs_pkg::SB_LEN-1].pv) begin
                r_out_data <= {r_sb[uvs_pkg::SB_LEN-1].nxt,
                               r_sb[uvs_pkg::SB_LEN-1].cur,
                               r_tx[uvs_pkg::TX_LEN-1].v,
                               r_tx[uvs_pkg::TX_LEN-1].u,
                               uvs_pkg::to_coord(r_pz, uvs_pkg::SH_PROD),
                               uvs_pkg::to_coord(64'(r_py), uvs_pkg::SH_COS),
                               uvs_pkg::to_coord(r_px, uvs_pkg::SH_PROD)};
            end else begin
                r_out_data <= '0;
            end
            r_out_user <= {r_sb[uvs_pkg::SB_LEN-1].qv, r_sb[uvs_pkg::SB_LEN-1].pv};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

>>> hw/rtl/uvs_checker.sv
// Port-level checks of the UV sphere vertex generator, bound to the top level.
module uvs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic [15:0]   s_axis_tdata,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [111:0]  m_axis_tdata,
    input logic [1:0]    m_axis_tuser,
    input logic          i_cfg_we,
    input logic          i_cfg_idx,
    input logic [7:0]    i_cfg_data
);

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed during stall");

    // A stalled output blocks the input side.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input ready while output stalled");

    // A quad starts only at a valid point.
    a_quad_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tuser[1] || m_axis_tuser[0]))
        else $error("quad flagged at invalid point");

    // Points outside the mesh carry all-zero data.
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
        else $error("invalid point carries data");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);

>>> bench/tb.sv
// Testbench for the UV sphere vertex generator: directed and random grid points checked by a predictor.
`timescale 1ns / 100ps

module tb;

    // Expected content of one output transfer.
    typedef struct {
        logic [15:0] x, y, z, u, v, cur, nxt;
        logic        pv, qv;
    } t_vertex;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [7:0]   i_cfg_data = '0;

    // Bench copy of the count registers.
    logic [7:0]   sectors = uvs_pkg::SECTOR_RESET;
    logic [7:0]   stacks = uvs_pkg::STACK_RESET;

    t_vertex      vertex_queue[$];
    int           mismatches = 0;
    bit           quiet = 1'b0;
    int           ready_stall = 0;

    uv_sphere_vertex_generator dut (.*);

    always #5 i_clk = ~i_clk;

    // Sine and cosine in Q30 of an angle given as a 32-bit fraction of a turn.
    function automatic void turn_sincos(input logic [31:0] a, output longint sn,
                                        output longint cs);
        logic [63:0] one, r, x, x2, t, s0, c0;
        logic        fold;
        longint      s, c;
        one = 64'd1 << 30;
        r = {34'd0, a[29:0]};
        fold = r > (one >> 1);
        if (fold) r = one - r;
        x = (r * 64'd3373259426 + one) >> 31;
        x2 = (x * x) >> 30;
        t = one - ((x2 * one) >> 30) / 110;
        t = one - ((x2 * t) >> 30) / 72;
        t = one - ((x2 * t) >> 30) / 42;
        t = one - ((x2 * t) >> 30) / 20;
        t = one - ((x2 * t) >> 30) / 6;
        s0 = (x * t) >> 30;
        t = one - ((x2 * one) >> 30) / 132;
        t = one - ((x2 * t) >> 30) / 90;
        t = one - ((x2 * t) >> 30) / 56;
        t = one - ((x2 * t) >> 30) / 30;
        t = one - ((x2 * t) >> 30) / 12;
        c0 = one - ((x2 * t) >> 30) / 2;
        s = fold ? longint'(c0) : longint'(s0);
        c = fold ? longint'(s0) : longint'(c0);
        case (a[31:30])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    // Round half away from zero by sh bits and saturate to signed 16 bits.
    function automatic logic [15:0] round_coord(input longint v, input int sh);
        logic [63:0] m;
        longint      r;
        m = (v < 0) ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        if (m > 64'd32768) m = 64'd32768;
        r = (v < 0) ? -longint'(m) : longint'(m);
        if (r > 32767) r = 32767;
        return r[15:0];
    endfunction

    // Expected vertex for grid point (i, j) at the current counts.
    function automatic t_vertex predict_vertex(input logic [7:0] i, input logic [7:0] j);
        t_vertex     e;
        logic [63:0] secs, stks, cur;
        logic [31:0] phi, theta;
        longint      sp, cp, st, ct;
        secs = 64'(sectors);
        stks = 64'(stacks);
        e = '{default: '0};
        e.pv = secs != 0 && stks != 0 && i <= stks && j <= secs;
        e.qv = e.pv && i < stks && j < secs;
        if (e.pv) begin
            phi = 32'(((64'(i) << 32) + stks) / (2 * stks));
            theta = 32'(((64'(j) << 33) + secs) / (2 * secs));
            turn_sincos(phi, sp, cp);
            turn_sincos(theta, st, ct);
            e.x = round_coord(sp * ct, 60 - uvs_pkg::COORD_FRAC_BITS);
            e.y = round_coord(cp, 30 - uvs_pkg::COORD_FRAC_BITS);
            e.z = round_coord(sp * st, 60 - uvs_pkg::COORD_FRAC_BITS);
            e.u = 16'(((64'(j) << 16) + secs) / (2 * secs));
            e.v = 16'(((64'(i) << 16) + stks) / (2 * stks));
            cur = 64'(i) * (secs + 1) + 64'(j);
            e.cur = cur[15:0];
            e.nxt = e.qv ? 16'(cur + secs + 1) : 16'd0;
        end
        return e;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Output ready with random stall bursts.
    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_stall <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare every output transfer with the oldest expected vertex.
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (vertex_queue.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata[15:0], 16'd0);
            end else begin
                e = vertex_queue.pop_front();
                if (m_axis_tdata[15:0] !== e.x) report_mismatch("pos_x", m_axis_tdata[15:0], e.x);
                if (m_axis_tdata[31:16] !== e.y) report_mismatch("pos_y", m_axis_tdata[31:16], e.y);
                if (m_axis_tdata[47:32] !== e.z) report_mismatch("pos_z", m_axis_tdata[47:32], e.z);
                if (m_axis_tdata[63:48] !== e.u) report_mismatch("tex_u", m_axis_tdata[63:48], e.u);
                if (m_axis_tdata[79:64] !== e.v) report_mismatch("tex_v", m_axis_tdata[79:64], e.v);
                if (m_axis_tdata[95:80] !== e.cur)
                    report_mismatch("corner_cur", m_axis_tdata[95:80], e.cur);
                if (m_axis_tdata[111:96] !== e.nxt)
                    report_mismatch("corner_next", m_axis_tdata[111:96], e.nxt);
                if (m_axis_tuser[0] !== e.pv)
                    report_mismatch("point_valid", 16'(m_axis_tuser[0]), 16'(e.pv));
                if (m_axis_tuser[1] !== e.qv)
                    report_mismatch("quad_valid", 16'(m_axis_tuser[1]), 16'(e.qv));
            end
        end
    end

    // Send one grid point and record its expected vertex once the transfer happens.
    task automatic send_point(input logic [7:0] i, input logic [7:0] j);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {j, i};
        do @(posedge i_clk); while (!s_axis_tready);
        vertex_queue = {vertex_queue, predict_vertex(i, j)};
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Let the pipeline empty completely.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (vertex_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Write both counts while the block is idle.
    task automatic set_counts(input logic [7:0] secs, input logic [7:0] stks);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= uvs_pkg::REG_SECTOR_COUNT;
        i_cfg_data <= secs;
        @(posedge i_clk);
        i_cfg_idx <= uvs_pkg::REG_STACK_COUNT;
        i_cfg_data <= stks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sectors = secs;
        stacks = stks;
    endtask

    // Reset counts: poles, last row and column, and points just outside.
    task automatic test_reset_counts();
        send_point(8'd0, 8'd0);
        send_point(8'd16, 8'd24);
        send_point(8'd8, 8'd12);
        send_point(8'd15, 8'd23);
        send_point(8'd17, 8'd0);
        send_point(8'd0, 8'd25);
    endtask

    // Largest and smallest counts with extreme indexes.
    task automatic test_count_extremes();
        set_counts(8'd255, 8'd255);
        send_point(8'd0, 8'd0);
        send_point(8'd255, 8'd255);
        send_point(8'd254, 8'd254);
        send_point(8'd128, 8'd64);
        send_point(8'd255, 8'd0);
        set_counts(8'd1, 8'd1);
        send_point(8'd0, 8'd0);
        send_point(8'd1, 8'd1);
        send_point(8'd0, 8'd1);
        send_point(8'd1, 8'd0);
        send_point(8'd2, 8'd0);
    endtask

    // A zero count makes every point invalid.
    task automatic test_zero_counts();
        set_counts(8'd0, 8'd5);
        send_point(8'd0, 8'd0);
        send_point(8'd3, 8'd3);
        set_counts(8'd5, 8'd0);
        send_point(8'd0, 8'd0);
        send_point(8'd255, 8'd255);
    endtask

    // Random counts; mostly points on or next to the mesh, some anywhere.
    task automatic test_random_mesh();
        logic [7:0] secs, stks, i, j;
        for (int ph = 0; ph < 14; ph++) begin
            secs = (ph % 5 == 1) ? 8'd255 : (ph % 5 == 3) ? 8'd1 : 8'($urandom_range(1, 255));
            stks = (ph % 4 == 2) ? 8'd255 : (ph % 4 == 0) ? 8'd1 : 8'($urandom_range(1, 255));
            set_counts(secs, stks);
            if (ph >= 12) quiet = 1'b1;
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    i = 8'($urandom);
                    j = 8'($urandom);
                end else begin
                    i = 8'($urandom_range(0, (stks == 255) ? 255 : stks + 1));
                    j = 8'($urandom_range(0, (secs == 255) ? 255 : secs + 1));
                end
                send_point(i, j);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_counts();
        test_count_extremes();
        test_zero_counts();
        test_random_mesh();
        wait_drained();
        if (mismatches == 0 && vertex_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Give up if the run hangs.
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_div_cell.sv
hw/rtl/uvs_horner_step.sv
hw/rtl/uvs_sincos.sv
hw/rtl/uv_sphere_vertex_generator.sv
hw/rtl/uvs_checker.sv
bench/tb.sv
